[rtl/allocation_tracking_table_defines.svh]
// Assertion macros for the allocation tracking table.
// Included by the top level; expects signals clk and rst in scope.
`ifndef ALLOCATION_TRACKING_TABLE_DEFINES_SVH
`define ALLOCATION_TRACKING_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define ATT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocation tracking table check failed");
`define ATT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocation tracking table check failed");
`else
`define ATT_ASSERT_IMP(lbl, ante, cons)
`define ATT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/att_pkg.sv]
// Shared types, codes and constants of the allocation tracking table.
// Used by every module of the block but att_ram; depends on nothing.
`default_nettype none
package att_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 64;
  localparam int unsigned LIST_MAX_DEF    = 8;
  // Wide enough for a per-caller count at the largest supported table depth.
  localparam int unsigned CNT_W           = 11;
  localparam int unsigned CFG_ADDR_W      = 5;

  localparam logic [2:0] REQ_RECORD   = 3'd0;
  localparam logic [2:0] REQ_RELEASE  = 3'd1;
  localparam logic [2:0] REQ_AGE      = 3'd2;
  localparam logic [2:0] REQ_REPORT   = 3'd3;
  localparam logic [2:0] REQ_SNAPSHOT = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_MISMATCH  = 2'd3;

  localparam logic [2:0] KIND_TOP    = 3'd0;
  localparam logic [2:0] KIND_NEWP   = 3'd1;
  localparam logic [2:0] KIND_PERM   = 3'd2;
  localparam logic [2:0] KIND_BYTES  = 3'd3;
  localparam logic [2:0] KIND_STATUS = 3'd4;

  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_TOP_LEN   = 3'd1;
  localparam logic [2:0] REG_PERM_LEN  = 3'd2;
  localparam logic [2:0] REG_NEWP_LEN  = 3'd3;
  localparam logic [2:0] REG_SNAP_LEN  = 3'd4;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] block_address;
    logic [31:0] caller_address;
    logic [31:0] block_bytes;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  list_kind;
    logic [31:0] report_caller;
    logic [6:0]  report_count;
    logic [31:0] report_bytes;
    logic [31:0] report_min_age;
    logic        last;
  } res_t;

  typedef struct packed {
    logic        valid;
    logic        permanent;
    logic        reported;
    logic [31:0] block;
    logic [31:0] caller;
    logic [31:0] bytes;
    logic [31:0] age;
  } entry_t;

  typedef struct packed {
    logic [31:0]      caller;
    logic [CNT_W-1:0] count;
    logic [31:0]      bytes;
    logic [31:0]      min_age;
  } rank_t;

  typedef struct packed {
    logic [31:0] threshold;
    logic [3:0]  top_len;
    logic [3:0]  perm_len;
    logic [3:0]  newp_len;
    logic [3:0]  snap_len;
  } cfg_t;

  typedef enum logic [1:0] {
    FLAG_CLR_BOTH, FLAG_SET_REP, FLAG_SET_PERM, FLAG_CLR_REP_ALL
  } flag_mode_t;

  typedef enum logic [1:0] {SEL_TOP, SEL_NEWP, SEL_PERM} emit_sel_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_REC_FIND, S_REL_FIND, S_REL_DOWN, S_AGE, S_FLAG_INIT, S_FLAG,
    S_RPT_OUTER, S_RPT_GATHER, S_RPT_DECIDE, S_RPT_ADV, S_RPT_FINAL, S_EMIT, S_STATUS
  } seq_state_t;

endpackage
`default_nettype wire

[rtl/att_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none
module att_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/att_rank.sv]
// One ranked or appended list of caller summaries with its fill count.
// Depends on att_pkg for rank_t.
`default_nettype none
module att_rank #(
  parameter int unsigned LIST_MAX = 8,
  localparam int unsigned LEN_W  = $clog2(LIST_MAX + 1),
  localparam int unsigned LIDX_W = (LIST_MAX > 1) ? $clog2(LIST_MAX) : 1
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                clear,
  input  wire logic                insert,
  input  wire logic                append,
  input  wire logic                by_bytes,
  input  wire logic [LEN_W-1:0]    len,
  input  wire att_pkg::rank_t      item,
  input  wire logic [31:0]         probe_caller,
  output logic                     hit,
  output logic      [LEN_W-1:0]    filled,
  input  wire logic [LIDX_W-1:0]   rd_idx,
  output att_pkg::rank_t           rd_item
);
  import att_pkg::*;

  rank_t               slot [LIST_MAX];
  rank_t               shift_src [LIST_MAX];
  logic [LIST_MAX-1:0] cand;
  logic                found;
  logic [LIDX_W-1:0]   pos;

  // Insert lands at the first slot below len whose holder ranks no higher; slots past the
  // fill count always qualify. Append only takes the slot at the fill count.
  always_comb begin
    for (int i = 0; i < LIST_MAX; i++) begin
      cand[i] = (i < int'(len)) &&
                (append ? (i == int'(filled)) :
                 ((i >= int'(filled)) ||
                  (by_bytes ? (item.bytes >= slot[i].bytes)
                            : (item.count >= slot[i].count))));
    end
    found = 1'b0;
    pos   = '0;
    for (int i = 0; i < LIST_MAX; i++) begin
      if (cand[i] && !found) begin
        found = 1'b1;
        pos   = LIDX_W'(i);
      end
    end
    hit = 1'b0;
    for (int i = 0; i < LIST_MAX; i++) begin
      if ((i < int'(filled)) && (slot[i].caller == probe_caller)) begin
        hit = 1'b1;
      end
    end
    shift_src[0] = item;
    for (int j = 1; j < LIST_MAX; j++) begin
      shift_src[j] = slot[j-1];
    end
  end

  assign rd_item = slot[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (clear) begin
      filled <= '0;
    end else if ((insert || append) && found && (filled < len)) begin
      filled <= filled + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!clear && (insert || append) && found) begin
      for (int j = 0; j < LIST_MAX; j++) begin
        if (j == int'(pos)) begin
          slot[j] <= item;
        end else if ((j < int'(len)) && (j > int'(pos))) begin
          slot[j] <= shift_src[j];
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/att_seq.sv]
// Request sequencer: scans the entry memory with read-modify-write passes,
// builds the report lists and emits results. Depends on att_pkg and att_rank.
`default_nettype none
module att_seq #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned LIST_MAX    = 8,
  localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH),
  localparam int unsigned LEN_W  = $clog2(LIST_MAX + 1),
  localparam int unsigned LIDX_W = (LIST_MAX > 1) ? $clog2(LIST_MAX) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire att_pkg::req_t     req,
  input  wire att_pkg::cfg_t     cfg,
  input  wire logic              out_free,
  output logic                   emit_valid,
  output att_pkg::res_t          emit_res,
  output logic                   mem_re,
  output logic      [IDX_W-1:0]  mem_raddr,
  output logic                   mem_we,
  output logic      [IDX_W-1:0]  mem_waddr,
  output att_pkg::entry_t        mem_wdata,
  input  wire att_pkg::entry_t   mem_rdata
);
  import att_pkg::*;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [3:0] v);
    return (32'(v) > LIST_MAX) ? LEN_W'(LIST_MAX) : LEN_W'(v);
  endfunction

  seq_state_t state, state_next;
  logic [IDX_W-1:0] cnt, cnt_next, end_idx, end_next;
  logic             down, down_next, iss_on, iss_on_next;
  logic             rd_vld, rd_last;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] highest, highest_next, oi, oi_next;
  logic [31:0]      total, total_next, sum, sum_next;
  req_t             r_req, r_req_next;
  flag_mode_t       flag_mode, flag_mode_next;
  seq_state_t       flag_ret, flag_ret_next;
  logic [31:0]      flag_caller, flag_caller_next;
  logic [31:0]      g_caller, g_caller_next, g_bytes, g_bytes_next, g_min, g_min_next;
  logic [CNT_W-1:0] g_cnt, g_cnt_next;
  logic             g_ap, g_ap_next, g_ar, g_ar_next;
  logic             snap, snap_next;
  logic [1:0]       st, st_next;
  emit_sel_t        sel, sel_next;
  logic [LEN_W-1:0] eidx, eidx_next;

  logic             issue, leave, start, ps_down;
  logic [IDX_W-1:0] ps_start, ps_end;
  logic             list_clear, top_ins, newp_app, perm_app;
  logic             top_hit;
  logic [LEN_W-1:0] top_filled, newp_filled, perm_filled, cur_filled;
  logic [LEN_W-1:0] lt, lp, ln, ls;
  rank_t            g_item, top_rd, newp_rd, perm_rd, cur_rd;
  entry_t           d;

  assign lt = clamp_len(cfg.top_len);
  assign lp = clamp_len(cfg.perm_len);
  assign ln = clamp_len(cfg.newp_len);
  assign ls = clamp_len(cfg.snap_len);
  assign d  = mem_rdata;
  assign g_item = '{caller: g_caller, count: g_cnt, bytes: g_bytes, min_age: g_min};
  assign mem_raddr = cnt;
  assign mem_re = issue;

  att_rank #(.LIST_MAX(LIST_MAX)) u_top (
    .clk, .rst, .clear(list_clear), .insert(top_ins), .append(1'b0), .by_bytes(snap),
    .len(snap ? ls : lt), .item(g_item), .probe_caller(d.caller), .hit(top_hit),
    .filled(top_filled), .rd_idx(eidx[LIDX_W-1:0]), .rd_item(top_rd)
  );
  att_rank #(.LIST_MAX(LIST_MAX)) u_newp (
    .clk, .rst, .clear(list_clear), .insert(1'b0), .append(newp_app), .by_bytes(1'b0),
    .len(ln), .item(g_item), .probe_caller(d.caller), .hit(),
    .filled(newp_filled), .rd_idx(eidx[LIDX_W-1:0]), .rd_item(newp_rd)
  );
  att_rank #(.LIST_MAX(LIST_MAX)) u_perm (
    .clk, .rst, .clear(list_clear), .insert(1'b0), .append(perm_app), .by_bytes(1'b0),
    .len(lp), .item(g_item), .probe_caller(d.caller), .hit(),
    .filled(perm_filled), .rd_idx(eidx[LIDX_W-1:0]), .rd_item(perm_rd)
  );

  always_comb begin
    unique case (sel)
      SEL_TOP:  begin cur_filled = top_filled;  cur_rd = top_rd;  end
      SEL_NEWP: begin cur_filled = newp_filled; cur_rd = newp_rd; end
      SEL_PERM: begin cur_filled = perm_filled; cur_rd = perm_rd; end
      default:  begin cur_filled = '0;          cur_rd = perm_rd; end
    endcase
  end

  always_comb begin
    state_next = state;       cnt_next = cnt;           end_next = end_idx;
    down_next = down;         iss_on_next = iss_on;     highest_next = highest;
    total_next = total;       sum_next = sum;           r_req_next = r_req;
    flag_mode_next = flag_mode; flag_ret_next = flag_ret; flag_caller_next = flag_caller;
    g_caller_next = g_caller; g_bytes_next = g_bytes;   g_min_next = g_min;
    g_cnt_next = g_cnt;       g_ap_next = g_ap;         g_ar_next = g_ar;
    oi_next = oi;             snap_next = snap;         st_next = st;
    sel_next = sel;           eidx_next = eidx;
    req_stall = 1'b1;  issue = 1'b0;  leave = 1'b0;  start = 1'b0;
    ps_start = '0;     ps_end = '0;   ps_down = 1'b0;
    mem_we = 1'b0;     mem_waddr = rd_addr;  mem_wdata = d;
    list_clear = 1'b0; top_ins = 1'b0; newp_app = 1'b0; perm_app = 1'b0;
    emit_valid = 1'b0; emit_res = '0;

    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt;
        mem_wdata = '0;
        if (cnt == IDX_W'(TABLE_DEPTH - 1)) begin
          cnt_next   = '0;
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + IDX_W'(1);
        end
      end
      S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          r_req_next = req;
          st_next    = ST_OK;
          unique case (req.req_type)
            REQ_RECORD: begin
              if (req.block_address == '0) begin
                state_next = S_STATUS;
              end else begin
                start = 1'b1; ps_end = IDX_W'(TABLE_DEPTH - 1);
                state_next = S_REC_FIND;
              end
            end
            REQ_RELEASE: begin
              if (req.block_address == '0) begin
                state_next = S_STATUS;
              end else begin
                start = 1'b1; ps_end = highest;
                state_next = S_REL_FIND;
              end
            end
            REQ_AGE: begin
              start = 1'b1; ps_end = highest;
              state_next = S_AGE;
            end
            REQ_REPORT, REQ_SNAPSHOT: begin
              snap_next  = (req.req_type == REQ_SNAPSHOT);
              list_clear = 1'b1;
              sum_next   = '0;
              oi_next    = '0;
              start = 1'b1;
              state_next = S_RPT_OUTER;
            end
            default: state_next = S_STATUS;
          endcase
        end
      end
      S_REC_FIND: begin
        issue = iss_on;
        if (rd_vld) begin
          if (!d.valid) begin
            mem_we    = 1'b1;
            mem_wdata = '{valid: 1'b1, permanent: 1'b0, reported: 1'b0,
                          block: r_req.block_address, caller: r_req.caller_address,
                          bytes: r_req.block_bytes, age: '0};
            if (rd_addr > highest) highest_next = rd_addr;
            total_next       = total + r_req.block_bytes;
            flag_mode_next   = FLAG_CLR_BOTH;
            flag_caller_next = r_req.caller_address;
            flag_ret_next    = S_STATUS;
            leave      = 1'b1;
            state_next = S_FLAG_INIT;
          end else if (rd_last) begin
            st_next    = ST_FULL;
            leave      = 1'b1;
            state_next = S_STATUS;
          end
        end
      end
      S_REL_FIND: begin
        issue = iss_on;
        if (rd_vld) begin
          if (d.valid && (d.block == r_req.block_address)) begin
            mem_we     = 1'b1;
            mem_wdata  = '0;
            total_next = total - d.bytes;
            flag_mode_next   = FLAG_CLR_BOTH;
            flag_caller_next = r_req.caller_address;
            flag_ret_next    = S_STATUS;
            leave = 1'b1;
            // The index only moves down to a valid entry above index zero.
            if ((highest == rd_addr) && (rd_addr >= IDX_W'(2))) begin
              start = 1'b1; ps_start = rd_addr - IDX_W'(1); ps_end = IDX_W'(1);
              ps_down = 1'b1;
              state_next = S_REL_DOWN;
            end else begin
              state_next = S_FLAG_INIT;
            end
          end else if (rd_last) begin
            st_next    = ST_NOT_FOUND;
            leave      = 1'b1;
            state_next = S_STATUS;
          end
        end
      end
      S_REL_DOWN: begin
        issue = iss_on;
        if (rd_vld) begin
          if (d.valid) begin
            highest_next = rd_addr;
            leave        = 1'b1;
            state_next   = S_FLAG_INIT;
          end else if (rd_last) begin
            leave      = 1'b1;
            state_next = S_FLAG_INIT;
          end
        end
      end
      S_AGE: begin
        issue = iss_on;
        if (rd_vld) begin
          if (d.valid) begin
            mem_we    = 1'b1;
            mem_wdata.age = d.age + 32'd1;
          end
          if (rd_last) begin
            leave      = 1'b1;
            state_next = S_STATUS;
          end
        end
      end
      S_FLAG_INIT: begin
        start = 1'b1; ps_end = highest;
        state_next = S_FLAG;
      end
      S_FLAG: begin
        issue = iss_on;
        if (rd_vld) begin
          if (d.valid) begin
            unique case (flag_mode)
              FLAG_CLR_BOTH: if (d.caller == flag_caller) begin
                mem_we = 1'b1; mem_wdata.permanent = 1'b0; mem_wdata.reported = 1'b0;
              end
              FLAG_SET_REP: if (d.caller == flag_caller) begin
                mem_we = 1'b1; mem_wdata.reported = 1'b1;
              end
              FLAG_SET_PERM: if (d.caller == flag_caller) begin
                mem_we = 1'b1; mem_wdata.permanent = 1'b1;
              end
              FLAG_CLR_REP_ALL: begin
                mem_we = 1'b1; mem_wdata.reported = 1'b0;
              end
              default: mem_we = 1'b0;
            endcase
          end
          if (rd_last) begin
            leave      = 1'b1;
            state_next = flag_ret;
          end
        end
      end
      S_RPT_OUTER: begin
        issue = iss_on;
        if (rd_vld) begin
          leave = 1'b1;
          if (!d.valid) begin
            state_next = S_RPT_ADV;
          end else begin
            if (!snap) sum_next = sum + d.bytes;
            if (top_hit) begin
              state_next = S_RPT_ADV;
            end else begin
              g_caller_next = d.caller;
              g_cnt_next    = '0;
              g_bytes_next  = '0;
              g_min_next    = '1;
              g_ap_next     = 1'b1;
              g_ar_next     = 1'b1;
              start = 1'b1; ps_end = highest;
              state_next = S_RPT_GATHER;
            end
          end
        end
      end
      S_RPT_GATHER: begin
        issue = iss_on;
        if (rd_vld) begin
          if (d.valid && (d.caller == g_caller)) begin
            g_cnt_next   = g_cnt + CNT_W'(1);
            g_bytes_next = g_bytes + d.bytes;
            if (d.age < g_min) g_min_next = d.age;
            if (!d.permanent) g_ap_next = 1'b0;
            if (!d.reported) g_ar_next = 1'b0;
          end
          if (rd_last) begin
            leave      = 1'b1;
            state_next = S_RPT_DECIDE;
          end
        end
      end
      S_RPT_DECIDE: begin
        state_next       = S_RPT_ADV;
        flag_caller_next = g_caller;
        flag_ret_next    = S_RPT_ADV;
        priority if (snap) begin
          top_ins = 1'b1;
        end else if (g_ap) begin
          if (!g_ar && (perm_filled < lp)) begin
            perm_app       = 1'b1;
            flag_mode_next = FLAG_SET_REP;
            state_next     = S_FLAG_INIT;
          end
        end else if ((g_min > cfg.threshold) && (newp_filled < ln)) begin
          newp_app       = 1'b1;
          flag_mode_next = FLAG_SET_PERM;
          state_next     = S_FLAG_INIT;
        end else begin
          top_ins = 1'b1;
        end
      end
      S_RPT_ADV: begin
        if (oi == highest) begin
          state_next = S_RPT_FINAL;
        end else begin
          oi_next = oi + IDX_W'(1);
          start = 1'b1; ps_start = oi + IDX_W'(1); ps_end = oi + IDX_W'(1);
          state_next = S_RPT_OUTER;
        end
      end
      S_RPT_FINAL: begin
        sel_next   = SEL_TOP;
        eidx_next  = '0;
        state_next = S_EMIT;
        if (!snap) begin
          if (total != sum) begin
            st_next = ST_MISMATCH;
          end else if (perm_filled < lp) begin
            flag_mode_next = FLAG_CLR_REP_ALL;
            flag_ret_next  = S_EMIT;
            state_next     = S_FLAG_INIT;
          end
        end
      end
      S_EMIT: begin
        if (eidx < cur_filled) begin
          if (out_free) begin
            emit_valid = 1'b1;
            emit_res.status = ST_OK;
            unique case (sel)
              SEL_TOP:  emit_res.list_kind = snap ? KIND_BYTES : KIND_TOP;
              SEL_NEWP: emit_res.list_kind = KIND_NEWP;
              default:  emit_res.list_kind = KIND_PERM;
            endcase
            emit_res.report_caller  = cur_rd.caller;
            emit_res.report_count   = cur_rd.count[6:0];
            emit_res.report_bytes   = cur_rd.bytes;
            emit_res.report_min_age = cur_rd.min_age;
            emit_res.last           = 1'b0;
            eidx_next = eidx + LEN_W'(1);
          end
        end else begin
          eidx_next = '0;
          unique case (sel)
            SEL_TOP:  sel_next = SEL_NEWP;
            SEL_NEWP: sel_next = SEL_PERM;
            default:  state_next = S_STATUS;
          endcase
        end
      end
      S_STATUS: begin
        if (out_free) begin
          emit_valid = 1'b1;
          emit_res.status    = st;
          emit_res.list_kind = KIND_STATUS;
          emit_res.last      = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (issue) begin
      if (cnt == end_idx) begin
        iss_on_next = 1'b0;
      end else begin
        cnt_next = down ? cnt - IDX_W'(1) : cnt + IDX_W'(1);
      end
    end
    if (start) begin
      cnt_next    = ps_start;
      end_next    = ps_end;
      down_next   = ps_down;
      iss_on_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      cnt     <= '0;
      end_idx <= '0;
      down    <= 1'b0;
      iss_on  <= 1'b0;
      rd_vld  <= 1'b0;
      highest <= '0;
      total   <= '0;
      oi      <= '0;
      snap    <= 1'b0;
      st      <= ST_OK;
      sel     <= SEL_TOP;
      eidx    <= '0;
      flag_mode <= FLAG_CLR_BOTH;
      flag_ret  <= S_IDLE;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      end_idx <= end_next;
      down    <= down_next;
      iss_on  <= iss_on_next;
      rd_vld  <= issue && !leave;
      highest <= highest_next;
      total   <= total_next;
      oi      <= oi_next;
      snap    <= snap_next;
      st      <= st_next;
      sel     <= sel_next;
      eidx    <= eidx_next;
      flag_mode <= flag_mode_next;
      flag_ret  <= flag_ret_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_last     <= (cnt == end_idx);
    rd_addr     <= cnt;
    sum         <= sum_next;
    r_req       <= r_req_next;
    flag_caller <= flag_caller_next;
    g_caller    <= g_caller_next;
    g_cnt       <= g_cnt_next;
    g_bytes     <= g_bytes_next;
    g_min       <= g_min_next;
    g_ap        <= g_ap_next;
    g_ar        <= g_ar_next;
  end

endmodule
`default_nettype wire

[rtl/allocation_tracking_table.sv]
// Allocation tracking table. The entries live in one memory of TABLE_DEPTH words,
// each scanned one entry per cycle by read-modify-write passes; after reset a
// clearing sweep writes every entry before the first request is taken.
// Record searches all entries for a free slot, then makes one pass over
// entries 0..highest used index to clear the caller's flags. Release takes two or
// three such passes: the search, a downward search for the new highest index when
// the top entry above index one is freed, and the flag pass. Age takes one pass.
// Report and snapshot make an outer scan of entries 0..highest index, plus a pass
// over them for every caller that is gathered and again for every caller whose
// flags are set, and then emit their results.
// One request is worked on at a time; its results leave through an output
// register, so the next request is taken while the last result waits.
`default_nettype none
`include "allocation_tracking_table_defines.svh"
module allocation_tracking_table #(
  parameter int unsigned TABLE_DEPTH = att_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned LIST_MAX    = att_pkg::LIST_MAX_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             req_valid,
  output logic                                  req_stall,
  input  wire att_pkg::req_t                    req,
  output logic                                  res_valid,
  input  wire logic                             res_stall,
  output att_pkg::res_t                         res,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [att_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                      pwdata,
  output logic      [31:0]                      prdata,
  output logic                                  pready
);
  import att_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

  cfg_t             cfg;
  logic             cfg_we;
  logic [2:0]       reg_idx;
  logic             out_free, emit_valid;
  res_t             emit_res;
  logic             mem_re, mem_we;
  logic [IDX_W-1:0] mem_raddr, mem_waddr;
  entry_t           mem_wdata, mem_rdata;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= '0;
      cfg.top_len   <= 4'd8;
      cfg.perm_len  <= 4'd8;
      cfg.newp_len  <= 4'd8;
      cfg.snap_len  <= 4'd8;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_THRESHOLD: cfg.threshold <= pwdata;
        REG_TOP_LEN:   cfg.top_len   <= pwdata[3:0];
        REG_PERM_LEN:  cfg.perm_len  <= pwdata[3:0];
        REG_NEWP_LEN:  cfg.newp_len  <= pwdata[3:0];
        REG_SNAP_LEN:  cfg.snap_len  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_THRESHOLD: prdata = cfg.threshold;
      REG_TOP_LEN:   prdata = {28'd0, cfg.top_len};
      REG_PERM_LEN:  prdata = {28'd0, cfg.perm_len};
      REG_NEWP_LEN:  prdata = {28'd0, cfg.newp_len};
      REG_SNAP_LEN:  prdata = {28'd0, cfg.snap_len};
      default:       prdata = '0;
    endcase
  end

  att_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk, .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata)
  );

  att_seq #(.TABLE_DEPTH(TABLE_DEPTH), .LIST_MAX(LIST_MAX)) u_seq (
    .clk, .rst, .req_valid, .req_stall, .req, .cfg, .out_free,
    .emit_valid, .emit_res, .mem_re, .mem_raddr, .mem_we, .mem_waddr,
    .mem_wdata, .mem_rdata
  );

  assign out_free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit_valid) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid) begin
      res <= emit_res;
    end
  end

  `ATT_ASSERT_NXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
  `ATT_ASSERT_IMP(a_list_entry_form, res_valid && (res.list_kind != KIND_STATUS), (res.status == ST_OK) && !res.last)
  `ATT_ASSERT_IMP(a_status_form, res_valid && res.last, (res.list_kind == KIND_STATUS) && (res.report_caller == '0))

endmodule
`default_nettype wire

[tb/tb_allocation_tracking_table.sv]
// Self-checking testbench for the allocation tracking table.
// Depends on att_pkg and the allocation_tracking_table top level only.
`default_nettype none
module tb_allocation_tracking_table;
  timeunit 1ns;
  timeprecision 1ps;
  import att_pkg::*;

  localparam int DEPTH = 64;
  localparam int LMAX  = 8;

  typedef struct {
    logic [31:0] caller;
    int unsigned count;
    logic [31:0] bytes;
    logic [31:0] min_age;
  } tally_t;

  logic        clk, rst;
  logic        req_valid, req_stall, res_valid, res_stall;
  req_t        req;
  res_t        res;
  logic        psel, penable, pwrite, pready;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  allocation_tracking_table i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predicted state of the table and its registers.
  logic        m_valid[DEPTH], m_perm[DEPTH], m_rep[DEPTH];
  logic [31:0] m_block[DEPTH], m_caller[DEPTH], m_bytes[DEPTH], m_age[DEPTH];
  int unsigned m_high;
  logic [31:0] m_live;
  logic [31:0] m_threshold;
  logic [3:0]  m_len[5];
  tally_t      lst_top[LMAX], lst_newp[LMAX], lst_perm[LMAX], lst_snap[LMAX];

  res_t        expected_results[$];
  int          errors;
  int          burst_left;
  int          stall_mode;
  logic [31:0] caller_pool[6];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #300ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int unsigned clamp_len(logic [3:0] v);
    return (v > LMAX) ? LMAX : v;
  endfunction

  function automatic void mark_flags(logic [31:0] caller, bit all, bit perm, logic val);
    for (int i = 0; i <= m_high; i++) begin
      if (!m_valid[i] || (!all && m_caller[i] != caller)) continue;
      if (perm) m_perm[i] = val;
      else m_rep[i] = val;
    end
  endfunction

  function automatic void gather_caller(logic [31:0] caller, output tally_t t,
                                        output bit all_perm, output bit all_rep);
    t.caller = caller; t.count = 0; t.bytes = 0; t.min_age = '1;
    all_perm = 1; all_rep = 1;
    for (int i = 0; i <= m_high; i++) begin
      if (!m_valid[i] || m_caller[i] != caller) continue;
      t.count++;
      t.bytes += m_bytes[i];
      if (m_age[i] < t.min_age) t.min_age = m_age[i];
      if (!m_perm[i]) all_perm = 0;
      if (!m_rep[i]) all_rep = 0;
    end
  endfunction

  function automatic bit listed(ref tally_t l[LMAX], input int unsigned filled,
                                input logic [31:0] caller);
    for (int i = 0; i < filled; i++) if (l[i].caller == caller) return 1;
    return 0;
  endfunction

  function automatic void rank_in(ref tally_t l[LMAX], input int unsigned len,
                                  ref int unsigned filled, input tally_t t, input bit by_bytes);
    bit ge;
    for (int i = 0; i < len; i++) begin
      ge = by_bytes ? (t.bytes >= l[i].bytes) : (t.count >= l[i].count);
      if (ge) begin
        for (int j = len - 1; j > i; j--) l[j] = l[j-1];
        l[i] = t;
        if (filled < len) filled++;
        return;
      end
    end
  endfunction

  function automatic void push_result(logic [1:0] st, logic [2:0] kind, tally_t t, bit fin);
    res_t r;
    r.status = st; r.list_kind = kind; r.last = fin;
    r.report_caller  = fin ? '0 : t.caller;
    r.report_count   = fin ? '0 : t.count[6:0];
    r.report_bytes   = fin ? '0 : t.bytes;
    r.report_min_age = fin ? '0 : t.min_age;
    expected_results.push_back(r);
  endfunction

  function automatic void clear_lists();
    tally_t z;
    z = '{default: 0};
    for (int i = 0; i < LMAX; i++) begin
      lst_top[i] = z; lst_newp[i] = z; lst_perm[i] = z; lst_snap[i] = z;
    end
  endfunction

  // Predicts all results of one accepted request and updates the table copy.
  function automatic void predict_request(req_t r);
    tally_t t, none;
    bit ap, ar, done;
    logic [1:0] st;
    int unsigned lt, lp, ln, ls, ft, fp, fn, fs;
    logic [31:0] sum;
    none = '{default: 0};
    st = ST_OK;
    case (r.req_type)
      REQ_RECORD: if (r.block_address != 0) begin
        done = 0;
        for (int i = 0; i < DEPTH && !done; i++) begin
          if (m_valid[i]) continue;
          m_valid[i] = 1; m_block[i] = r.block_address; m_caller[i] = r.caller_address;
          m_bytes[i] = r.block_bytes; m_age[i] = 0; m_perm[i] = 0; m_rep[i] = 0;
          if (i > m_high) m_high = i;
          m_live += r.block_bytes;
          mark_flags(r.caller_address, 0, 1, 0);
          mark_flags(r.caller_address, 0, 0, 0);
          done = 1;
        end
        if (!done) st = ST_FULL;
      end
      REQ_RELEASE: if (r.block_address != 0) begin
        done = 0;
        for (int i = 0; i <= m_high && !done; i++) begin
          if (!m_valid[i] || m_block[i] != r.block_address) continue;
          m_live -= m_bytes[i];
          m_valid[i] = 0; m_block[i] = 0; m_caller[i] = 0; m_bytes[i] = 0;
          m_age[i] = 0; m_perm[i] = 0; m_rep[i] = 0;
          // The highest index only moves down to a valid entry above index 0.
          if (m_high == i)
            for (int p = i; p > 0; p--) if (m_valid[p]) begin m_high = p; break; end
          mark_flags(r.caller_address, 0, 1, 0);
          mark_flags(r.caller_address, 0, 0, 0);
          done = 1;
        end
        if (!done) st = ST_NOT_FOUND;
      end
      REQ_AGE:
        for (int i = 0; i <= m_high; i++) if (m_valid[i]) m_age[i]++;
      REQ_REPORT: begin
        lt = clamp_len(m_len[REG_TOP_LEN]);
        lp = clamp_len(m_len[REG_PERM_LEN]);
        ln = clamp_len(m_len[REG_NEWP_LEN]);
        ft = 0; fp = 0; fn = 0; sum = 0;
        clear_lists();
        for (int i = 0; i <= m_high; i++) begin
          if (!m_valid[i]) continue;
          sum += m_bytes[i];
          if (listed(lst_top, ft, m_caller[i])) continue;
          gather_caller(m_caller[i], t, ap, ar);
          if (ap) begin
            if (!ar && fp < lp) begin
              lst_perm[fp++] = t;
              mark_flags(t.caller, 0, 0, 1);
            end
            continue;
          end
          if (t.min_age > m_threshold && fn < ln) begin
            mark_flags(t.caller, 0, 1, 1);
            lst_newp[fn++] = t;
            continue;
          end
          rank_in(lst_top, lt, ft, t, 0);
        end
        if (m_live != sum) st = ST_MISMATCH;
        else if (fp < lp) mark_flags(0, 1, 0, 0);
        for (int i = 0; i < ft; i++) push_result(ST_OK, KIND_TOP, lst_top[i], 0);
        for (int i = 0; i < fn; i++) push_result(ST_OK, KIND_NEWP, lst_newp[i], 0);
        for (int i = 0; i < fp; i++) push_result(ST_OK, KIND_PERM, lst_perm[i], 0);
      end
      REQ_SNAPSHOT: begin
        ls = clamp_len(m_len[REG_SNAP_LEN]);
        fs = 0;
        clear_lists();
        for (int i = 0; i <= m_high; i++) begin
          if (!m_valid[i]) continue;
          if (listed(lst_snap, fs, m_caller[i])) continue;
          gather_caller(m_caller[i], t, ap, ar);
          rank_in(lst_snap, ls, fs, t, 1);
        end
        for (int i = 0; i < fs; i++) push_result(ST_OK, KIND_BYTES, lst_snap[i], 0);
      end
      default: ;
    endcase
    push_result(st, KIND_STATUS, none, 1);
  endfunction

  // Sends one request; valid is lowered only by a gap between bursts.
  task automatic send_request(logic [2:0] kind, logic [31:0] blk, logic [31:0] caller,
                              logic [31:0] nbytes);
    req_t r;
    if (burst_left <= 0) begin
      @(negedge clk);
      req_valid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    r.req_type = kind; r.block_address = blk; r.caller_address = caller;
    r.block_bytes = nbytes;
    @(negedge clk);
    req_valid <= 1'b1;
    req <= r;
    forever begin
      #1;
      if (!req_stall) break;
      @(negedge clk);
    end
    predict_request(r);
    @(posedge clk);
    burst_left--;
  endtask

  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= CFG_ADDR_W'(idx) << 2; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == REG_THRESHOLD) m_threshold = value;
    else m_len[idx] = value[3:0];
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_config(logic [31:0] thr, logic [3:0] lt, logic [3:0] lp,
                            logic [3:0] ln, logic [3:0] ls);
    drain();
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_TOP_LEN, lt);
    write_reg(REG_PERM_LEN, lp);
    write_reg(REG_NEWP_LEN, ln);
    write_reg(REG_SNAP_LEN, ls);
  endtask

  function automatic logic [31:0] live_block();
    int i;
    for (int n = 0; n < 8; n++) begin
      i = $urandom_range(0, DEPTH - 1);
      if (m_valid[i]) return m_block[i];
    end
    for (i = 0; i < DEPTH; i++) if (m_valid[i]) return m_block[i];
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_caller();
    return ($urandom_range(0, 15) == 0) ? $urandom : caller_pool[$urandom_range(0, 5)];
  endfunction

  task automatic test_basic_requests();
    send_request(REQ_RECORD, 32'h0, 32'h100, 32'd5);
    send_request(REQ_RELEASE, 32'h0, 32'h100, 32'd0);
    send_request(REQ_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_RECORD, 32'h0000_0001, 32'h0, 32'h1);
    send_request(REQ_RECORD, 32'h5555_AAAA, 32'hAAAA_5555, 32'h8000_0000);
    send_request(REQ_RECORD, 32'h1234, 32'hAAAA_5555, 32'h10);
    send_request(REQ_SNAPSHOT, '0, '0, '0);
    send_request(REQ_AGE, '0, '0, '0);
    send_request(REQ_REPORT, '0, '0, '0);
    send_request(REQ_REPORT, '0, '0, '0);
    send_request(REQ_AGE, '0, '0, '0);
    send_request(REQ_REPORT, '0, '0, '0);
    send_request(REQ_RELEASE, 32'hDEAD_BEEF, 32'h100, '0);
    // The releasing caller differs from the owner of the freed entry.
    send_request(REQ_RELEASE, 32'h1234, 32'hFFFF_FFFF, '0);
    send_request(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(3'd6, '0, '0, '0);
    send_request(3'd7, '0, '0, '0);
    send_request(REQ_REPORT, '0, '0, '0);
    send_request(REQ_RELEASE, 32'hFFFF_FFFF, 32'h0, '0);
    send_request(REQ_SNAPSHOT, '0, '0, '0);
  endtask

  task automatic test_list_settings();
    set_config(32'hFFFF_FFFF, 4'd0, 4'd0, 4'd0, 4'd0);
    send_request(REQ_REPORT, '0, '0, '0);
    send_request(REQ_SNAPSHOT, '0, '0, '0);
    set_config(32'd0, 4'd15, 4'd15, 4'd15, 4'd15);
    send_request(REQ_AGE, '0, '0, '0);
    send_request(REQ_REPORT, '0, '0, '0);
    send_request(REQ_SNAPSHOT, '0, '0, '0);
    set_config(32'd1, 4'd1, 4'd2, 4'd1, 4'd3);
    send_request(REQ_REPORT, '0, '0, '0);
  endtask

  task automatic test_full_table();
    set_config(32'd3, 4'd8, 4'd8, 4'd8, 4'd8);
    for (int i = 0; i < DEPTH + 2; i++)
      send_request(REQ_RECORD, 32'h1000 + i, caller_pool[i % 3], $urandom_range(1, 64));
    send_request(REQ_REPORT, '0, '0, '0);
    send_request(REQ_SNAPSHOT, '0, '0, '0);
    for (int i = DEPTH - 1; i >= 0; i--)
      send_request(REQ_RELEASE, 32'h1000 + i, caller_pool[i % 3], '0);
  endtask

  task automatic test_random_traffic(int count);
    int sel;
    for (int n = 0; n < count; n++) begin
      if (n % 80 == 79)
        set_config($urandom_range(0, 6), $urandom_range(0, 15), $urandom_range(0, 15),
                   $urandom_range(0, 15), $urandom_range(0, 15));
      sel = $urandom_range(0, 99);
      if (sel < 40)
        send_request(REQ_RECORD, ($urandom_range(0, 30) == 0) ? 32'h0 : $urandom,
                     pick_caller(), ($urandom_range(0, 3) == 0) ? $urandom
                                                               : $urandom_range(0, 255));
      else if (sel < 68)
        send_request(REQ_RELEASE, ($urandom_range(0, 9) == 0) ? $urandom : live_block(),
                     pick_caller(), $urandom);
      else if (sel < 84)
        send_request(REQ_AGE, $urandom, $urandom, $urandom);
      else if (sel < 92)
        send_request(REQ_REPORT, $urandom, $urandom, $urandom);
      else if (sel < 97)
        send_request(REQ_SNAPSHOT, $urandom, $urandom, $urandom);
      else
        send_request(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom);
    end
  endtask

  // Receiver stall pattern: switches between no stall, light and heavy stalling.
  always @(negedge clk) begin
    if ($urandom_range(0, 40) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: res_stall <= 1'b0;
      1: res_stall <= ($urandom_range(0, 3) == 0);
      default: res_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Outputs are stable between edges; a transaction completes at the next rising edge.
  initial begin
    res_t exp_r;
    forever begin
      @(negedge clk);
      #1;
      if (!rst && res_valid && !res_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, res);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("status", exp_r.status, res.status);
          check_field("list_kind", exp_r.list_kind, res.list_kind);
          check_field("report_caller", exp_r.report_caller, res.report_caller);
          check_field("report_count", exp_r.report_count, res.report_count);
          check_field("report_bytes", exp_r.report_bytes, res.report_bytes);
          check_field("report_min_age", exp_r.report_min_age, res.report_min_age);
          check_field("last", exp_r.last, res.last);
        end
      end
    end
  end

  initial begin
    rst = 1'b1; req_valid = 1'b0; req = '0; res_stall = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    errors = 0; burst_left = 0; stall_mode = 0;
    for (int i = 0; i < DEPTH; i++) begin
      m_valid[i] = 0; m_perm[i] = 0; m_rep[i] = 0;
      m_block[i] = 0; m_caller[i] = 0; m_bytes[i] = 0; m_age[i] = 0;
    end
    m_high = 0; m_live = 0; m_threshold = 0;
    m_len[0] = 0;
    for (int i = 1; i < 5; i++) m_len[i] = 4'd8;
    caller_pool[0] = 32'h0000_0040;
    for (int i = 1; i < 6; i++) caller_pool[i] = $urandom;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_basic_requests();
    test_list_settings();
    test_full_table();
    test_random_traffic(150);
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire
